/* hdl/ctl_pkg.sv */
package ctl_pkg;

    localparam int DEF_OFFSET_BITS   = 32;
    localparam int DEF_LINE_BITS     = 24;
    localparam int DEF_KEYWORD_CHARS = 8;

    localparam int KIND_W = 7;
    localparam int ERR_W  = 3;
    localparam int NUM_KW = 27;

    typedef logic [KIND_W-1:0] t_kind;
    typedef logic [ERR_W-1:0]  t_err;

    typedef enum logic [4:0] {
        M_IDLE, M_IDENT, M_DEC, M_ZERO, M_HEX0, M_HEX, M_OCT, M_CHAR0, M_CHAR1,
        M_STR, M_MINUS, M_PLUS, M_EQ, M_BANG, M_LT, M_GT, M_AMP, M_BAR
    } t_mode;

    localparam t_kind K_IDENT = 7'd0;
    localparam t_kind K_DEC   = 7'd1;
    localparam t_kind K_HEX   = 7'd2;
    localparam t_kind K_OCT   = 7'd3;
    localparam t_kind K_CHR   = 7'd4;
    localparam t_kind K_STR   = 7'd5;
    localparam t_kind K_KW    = 7'd6;
    localparam t_kind K_OP    = 7'd33;

    localparam t_kind K_LPAREN  = K_OP + 7'd0;
    localparam t_kind K_RPAREN  = K_OP + 7'd1;
    localparam t_kind K_LBRACK  = K_OP + 7'd2;
    localparam t_kind K_RBRACK  = K_OP + 7'd3;
    localparam t_kind K_LBRACE  = K_OP + 7'd4;
    localparam t_kind K_RBRACE  = K_OP + 7'd5;
    localparam t_kind K_SEMI    = K_OP + 7'd6;
    localparam t_kind K_COLON   = K_OP + 7'd7;
    localparam t_kind K_COMMA   = K_OP + 7'd8;
    localparam t_kind K_STAR    = K_OP + 7'd9;
    localparam t_kind K_DOT     = K_OP + 7'd10;
    localparam t_kind K_ARROW   = K_OP + 7'd11;
    localparam t_kind K_DECR    = K_OP + 7'd12;
    localparam t_kind K_MINUS   = K_OP + 7'd13;
    localparam t_kind K_INCR    = K_OP + 7'd14;
    localparam t_kind K_PLUS    = K_OP + 7'd15;
    localparam t_kind K_EQEQ    = K_OP + 7'd16;
    localparam t_kind K_ASSIGN  = K_OP + 7'd17;
    localparam t_kind K_SLASH   = K_OP + 7'd18;
    localparam t_kind K_PERCENT = K_OP + 7'd19;
    localparam t_kind K_NE      = K_OP + 7'd20;
    localparam t_kind K_BANG    = K_OP + 7'd21;
    localparam t_kind K_LE      = K_OP + 7'd22;
    localparam t_kind K_SHL     = K_OP + 7'd23;
    localparam t_kind K_LT      = K_OP + 7'd24;
    localparam t_kind K_GE      = K_OP + 7'd25;
    localparam t_kind K_SHR     = K_OP + 7'd26;
    localparam t_kind K_GT      = K_OP + 7'd27;
    localparam t_kind K_ANDAND  = K_OP + 7'd28;
    localparam t_kind K_AMP     = K_OP + 7'd29;
    localparam t_kind K_OROR    = K_OP + 7'd30;
    localparam t_kind K_BAR     = K_OP + 7'd31;
    localparam t_kind K_CARET   = K_OP + 7'd32;
    localparam t_kind K_TILDE   = K_OP + 7'd33;
    localparam t_kind K_QUEST   = K_OP + 7'd34;

    localparam t_err E_NONE     = 3'd0;
    localparam t_err E_NEWLINE  = 3'd1;
    localparam t_err E_EMPTY    = 3'd2;
    localparam t_err E_UNCLOSED = 3'd3;
    localparam t_err E_NOHEX    = 3'd4;
    localparam t_err E_UNEXPECT = 3'd5;

    localparam logic [63:0] KW_TEXT [NUM_KW] = '{
        "break", "case", "char", "const", "continue", "default", "do", "else",
        "enum", "extern", "for", "if", "int", "long", "return", "short",
        "signed", "sizeof", "static", "struct", "switch", "typedef", "union",
        "unsigned", "void", "volatile", "while"
    };
    localparam logic [3:0] KW_LEN [NUM_KW] = '{
        4'd5, 4'd4, 4'd4, 4'd5, 4'd8, 4'd7, 4'd2, 4'd4, 4'd4, 4'd6, 4'd3,
        4'd2, 4'd3, 4'd4, 4'd6, 4'd5, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd7,
        4'd5, 4'd8, 4'd4, 4'd8, 4'd5
    };

    function automatic t_kind kw_lookup(input logic [7:0][7:0] w, input logic [3:0] len,
                                        input logic len_ok);
        logic [63:0] v;
        t_kind       k;
        v = '0;
        k = K_IDENT;
        for (int i = 0; i < 8; i++) begin
            if (4'(i) < len) begin
                v = {v[55:0], w[i]};
            end
        end
        for (int i = 0; i < NUM_KW; i++) begin
            if (len_ok && len == KW_LEN[i] && v == KW_TEXT[i]) begin
                k = K_KW + KIND_W'(i);
            end
        end
        return k;
    endfunction

    function automatic logic [KIND_W:0] single_op(input logic [7:0] c);
        logic [KIND_W:0] r;
        r = '0;
        case (c)
            "(": r = {1'b1, K_LPAREN};
            ")": r = {1'b1, K_RPAREN};
            "[": r = {1'b1, K_LBRACK};
            "]": r = {1'b1, K_RBRACK};
            "{": r = {1'b1, K_LBRACE};
            "}": r = {1'b1, K_RBRACE};
            ";": r = {1'b1, K_SEMI};
            ":": r = {1'b1, K_COLON};
            ",": r = {1'b1, K_COMMA};
            "*": r = {1'b1, K_STAR};
            ".": r = {1'b1, K_DOT};
            "/": r = {1'b1, K_SLASH};
            "%": r = {1'b1, K_PERCENT};
            "^": r = {1'b1, K_CARET};
            "~": r = {1'b1, K_TILDE};
            "?": r = {1'b1, K_QUEST};
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic t_kind pending_op(input t_mode m);
        t_kind k;
        case (m)
            M_MINUS: k = K_MINUS;
            M_PLUS:  k = K_PLUS;
            M_EQ:    k = K_ASSIGN;
            M_BANG:  k = K_BANG;
            M_LT:    k = K_LT;
            M_GT:    k = K_GT;
            M_AMP:   k = K_AMP;
            M_BAR:   k = K_BAR;
            default: k = K_IDENT;
        endcase
        return k;
    endfunction

endpackage

/* hdl/ctl_scan.sv */
module ctl_scan
    import ctl_pkg::*;
#(
    parameter int OFFSET_BITS   = DEF_OFFSET_BITS,
    parameter int LINE_BITS     = DEF_LINE_BITS,
    parameter int KEYWORD_CHARS = DEF_KEYWORD_CHARS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_take,
    input  logic [7:0]             i_text_byte,
    input  logic                   i_end_of_text,
    output logic [1:0]             o_count,
    output t_kind                  o_kind   [2],
    output logic [OFFSET_BITS-1:0] o_start  [2],
    output logic [OFFSET_BITS-1:0] o_end    [2],
    output logic [LINE_BITS-1:0]   o_line   [2],
    output t_err                   o_err    [2],
    output logic                   o_last   [2]
);

    localparam int LW = $clog2(KEYWORD_CHARS + 2);
    localparam int IW = $clog2(KEYWORD_CHARS);
    localparam logic [OFFSET_BITS-1:0] OMAX = '1;
    localparam logic [LINE_BITS-1:0]   LMAX = '1;
    localparam logic [LINE_BITS-1:0]   LONE = LINE_BITS'(1);

    t_mode                  r_mode, n_mode;
    logic [7:0]             r_wbuf [KEYWORD_CHARS];
    logic [7:0]             n_wbuf [KEYWORD_CHARS];
    logic [LW-1:0]          r_wlen, n_wlen;
    logic [OFFSET_BITS-1:0] r_pos, n_pos;
    logic [LINE_BITS-1:0]   r_line, n_line;
    logic [OFFSET_BITS-1:0] r_tstart, n_tstart;
    logic [LINE_BITS-1:0]   r_tline, n_tline;
    logic                   r_esc, n_esc;
    logic                   r_halt, n_halt;

    logic [7:0]             c;
    logic [OFFSET_BITS-1:0] pos, nxt;
    logic                   is_dig, is_alp, is_xdg, is_oct, do_idle, do_fin;
    logic [KIND_W:0]        sop;
    logic [7:0][7:0]        w8;

    assign c      = i_text_byte;
    assign pos    = r_pos;
    assign nxt    = (r_pos == OMAX) ? r_pos : r_pos + 1'b1;
    assign is_dig = c >= "0" && c <= "9";
    assign is_alp = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    assign is_xdg = is_dig || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    assign is_oct = c >= "0" && c <= "7";
    assign sop    = single_op(c);

    always_comb begin
        n_mode   = r_mode;
        n_wbuf   = r_wbuf;
        n_wlen   = r_wlen;
        n_pos    = r_pos;
        n_line   = r_line;
        n_tstart = r_tstart;
        n_tline  = r_tline;
        n_esc    = r_esc;
        n_halt   = r_halt;
        o_count  = 2'd0;
        do_idle  = 1'b0;
        do_fin   = 1'b0;
        w8       = '0;
        for (int j = 0; j < 2; j++) begin
            o_kind[j]  = K_IDENT;
            o_start[j] = '0;
            o_end[j]   = '0;
            o_line[j]  = '0;
            o_err[j]   = E_NONE;
            o_last[j]  = 1'b0;
        end

        if (!r_halt) begin
            case (r_mode)
                M_IDLE: do_idle = 1'b1;
                M_IDENT: begin
                    if (is_alp || is_dig) begin
                        if (r_wlen < LW'(KEYWORD_CHARS)) n_wbuf[r_wlen[IW-1:0]] = c;
                        if (r_wlen <= LW'(KEYWORD_CHARS)) n_wlen = r_wlen + 1'b1;
                    end else begin
                        do_fin = 1'b1;
                    end
                end
                M_DEC: do_fin = !is_dig;
                M_ZERO: begin
                    if (c == "x" || c == "X") begin
                        n_mode   = M_HEX0;
                        n_tstart = nxt;
                    end else if (is_oct) begin
                        n_mode   = M_OCT;
                        n_tstart = pos;
                    end else if (is_dig) begin
                        n_mode = M_DEC;
                    end else begin
                        do_fin = 1'b1;
                    end
                end
                M_HEX0: begin
                    if (is_xdg) begin
                        n_mode = M_HEX;
                    end else begin
                        o_kind[0] = K_IDENT; o_start[0] = r_tstart; o_end[0] = nxt;
                        o_line[0] = r_line; o_err[0] = E_NOHEX; o_count = 2'd1;
                        n_halt = 1'b1; n_mode = M_IDLE;
                    end
                end
                M_HEX: do_fin = !is_xdg;
                M_OCT: do_fin = !is_oct;
                M_CHAR0: begin
                    if (r_esc) begin
                        n_esc = 1'b0;
                        if (c == 8'h0a) n_line = (r_line == LMAX) ? r_line : r_line + 1'b1;
                        n_mode = M_CHAR1;
                    end else if (c == "\\") begin
                        n_esc = 1'b1;
                    end else if (c == 8'h0a || c == "'") begin
                        o_kind[0] = K_IDENT; o_start[0] = r_tstart; o_end[0] = nxt;
                        o_line[0] = r_line; o_err[0] = (c == "'") ? E_EMPTY : E_NEWLINE;
                        o_count = 2'd1; n_halt = 1'b1; n_mode = M_IDLE;
                    end else begin
                        n_mode = M_CHAR1;
                    end
                end
                M_CHAR1: begin
                    o_start[0] = r_tstart;
                    o_count    = 2'd1;
                    n_mode     = M_IDLE;
                    if (c == "'") begin
                        o_kind[0] = K_CHR; o_end[0] = pos; o_line[0] = r_tline;
                    end else begin
                        o_kind[0] = K_IDENT; o_end[0] = nxt; o_line[0] = r_line;
                        o_err[0]  = (c == 8'h0a) ? E_NEWLINE : E_UNCLOSED;
                        n_halt    = 1'b1;
                    end
                end
                M_STR: begin
                    if (r_esc) begin
                        n_esc = 1'b0;
                        if (c == 8'h0a) n_line = (r_line == LMAX) ? r_line : r_line + 1'b1;
                    end else if (c == "\\") begin
                        n_esc = 1'b1;
                    end else if (c == 8'h0a) begin
                        o_kind[0] = K_IDENT; o_start[0] = r_tstart; o_end[0] = nxt;
                        o_line[0] = r_line; o_err[0] = E_NEWLINE; o_count = 2'd1;
                        n_halt = 1'b1; n_mode = M_IDLE;
                    end else if (c == "\"") begin
                        o_kind[0] = K_STR; o_start[0] = r_tstart; o_end[0] = pos;
                        o_line[0] = r_tline; o_count = 2'd1; n_mode = M_IDLE;
                    end
                end
                default: begin
                    o_start[0] = r_tstart;
                    o_line[0]  = r_tline;
                    o_count    = 2'd1;
                    n_mode     = M_IDLE;
                    o_end[0]   = nxt;
                    if (r_mode == M_MINUS && c == ">") o_kind[0] = K_ARROW;
                    else if (r_mode == M_MINUS && c == "-") o_kind[0] = K_DECR;
                    else if (r_mode == M_PLUS && c == "+") o_kind[0] = K_INCR;
                    else if (r_mode == M_EQ && c == "=") o_kind[0] = K_EQEQ;
                    else if (r_mode == M_BANG && c == "=") o_kind[0] = K_NE;
                    else if (r_mode == M_LT && c == "=") o_kind[0] = K_LE;
                    else if (r_mode == M_LT && c == "<") o_kind[0] = K_SHL;
                    else if (r_mode == M_GT && c == "=") o_kind[0] = K_GE;
                    else if (r_mode == M_GT && c == ">") o_kind[0] = K_SHR;
                    else if (r_mode == M_AMP && c == "&") o_kind[0] = K_ANDAND;
                    else if (r_mode == M_BAR && c == "|") o_kind[0] = K_OROR;
                    else begin
                        o_kind[0] = pending_op(r_mode);
                        o_end[0]  = pos;
                        do_idle   = 1'b1;
                    end
                end
            endcase

            if (do_fin) begin
                for (int i = 0; i < 8; i++) w8[i] = r_wbuf[i];
                case (r_mode)
                    M_IDENT: o_kind[0] = kw_lookup(w8, r_wlen[3:0],
                                                   r_wlen <= LW'(8));
                    M_HEX:   o_kind[0] = K_HEX;
                    M_OCT:   o_kind[0] = K_OCT;
                    default: o_kind[0] = K_DEC;
                endcase
                o_start[0] = r_tstart;
                o_end[0]   = pos;
                o_line[0]  = r_tline;
                o_count    = 2'd1;
                n_mode     = M_IDLE;
                do_idle    = 1'b1;
            end

            if (do_idle) begin
                if (c == " " || c == 8'h09) begin
                end else if (c == 8'h0a) begin
                    n_line = (n_line == LMAX) ? n_line : n_line + 1'b1;
                end else if (sop[KIND_W]) begin
                    o_kind[o_count[0]]  = sop[KIND_W-1:0];
                    o_start[o_count[0]] = pos;
                    o_end[o_count[0]]   = nxt;
                    o_line[o_count[0]]  = n_line;
                    o_err[o_count[0]]   = E_NONE;
                    o_count             = o_count + 1'b1;
                end else if (c == "-" || c == "+" || c == "=" || c == "!" || c == "<" ||
                             c == ">" || c == "&" || c == "|" || is_dig) begin
                    case (c)
                        "-":     n_mode = M_MINUS;
                        "+":     n_mode = M_PLUS;
                        "=":     n_mode = M_EQ;
                        "!":     n_mode = M_BANG;
                        "<":     n_mode = M_LT;
                        ">":     n_mode = M_GT;
                        "&":     n_mode = M_AMP;
                        "|":     n_mode = M_BAR;
                        "0":     n_mode = M_ZERO;
                        default: n_mode = M_DEC;
                    endcase
                    n_tstart = pos;
                    n_tline  = n_line;
                end else if (c == "'" || c == "\"") begin
                    n_mode   = (c == "'") ? M_CHAR0 : M_STR;
                    n_tstart = nxt;
                    n_tline  = n_line;
                    n_esc    = 1'b0;
                end else if (is_alp) begin
                    n_mode    = M_IDENT;
                    n_tstart  = pos;
                    n_tline   = n_line;
                    n_wbuf[0] = c;
                    n_wlen    = LW'(1);
                end else begin
                    o_kind[o_count[0]]  = K_IDENT;
                    o_start[o_count[0]] = pos;
                    o_end[o_count[0]]   = nxt;
                    o_line[o_count[0]]  = n_line;
                    o_err[o_count[0]]   = E_UNEXPECT;
                    o_count             = o_count + 1'b1;
                    n_halt              = 1'b1;
                    n_mode              = M_IDLE;
                end
            end

            n_pos = nxt;

            if (i_end_of_text && !n_halt) begin
                for (int i = 0; i < 8; i++) w8[i] = n_wbuf[i];
                if (n_mode != M_IDLE) begin
                    o_start[o_count[0]] = n_tstart;
                    o_end[o_count[0]]   = nxt;
                    o_line[o_count[0]]  = n_tline;
                    o_err[o_count[0]]   = E_NONE;
                end
                case (n_mode)
                    M_IDLE: begin
                    end
                    M_IDENT, M_DEC, M_ZERO, M_HEX, M_OCT: begin
                        case (n_mode)
                            M_IDENT: o_kind[o_count[0]] = kw_lookup(w8, n_wlen[3:0],
                                                                    n_wlen <= LW'(8));
                            M_HEX:   o_kind[o_count[0]] = K_HEX;
                            M_OCT:   o_kind[o_count[0]] = K_OCT;
                            default: o_kind[o_count[0]] = K_DEC;
                        endcase
                        o_count = o_count + 1'b1;
                    end
                    M_HEX0, M_CHAR0, M_CHAR1, M_STR: begin
                        o_kind[o_count[0]] = K_IDENT;
                        o_line[o_count[0]] = n_line;
                        o_err[o_count[0]]  = (n_mode == M_HEX0) ? E_NOHEX : E_UNCLOSED;
                        o_count            = o_count + 1'b1;
                        n_halt             = 1'b1;
                    end
                    default: begin
                        o_kind[o_count[0]] = pending_op(n_mode);
                        o_count            = o_count + 1'b1;
                    end
                endcase
                n_mode = M_IDLE;
                if (!n_halt) begin
                    n_wlen   = '0;
                    n_pos    = '0;
                    n_line   = LONE;
                    n_tstart = '0;
                    n_tline  = LONE;
                    n_esc    = 1'b0;
                end
            end

            if (o_count == 2'd1) o_last[0] = 1'b1;
            if (o_count == 2'd2) o_last[1] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_IDLE;
            r_wlen   <= '0;
            r_pos    <= '0;
            r_line   <= LONE;
            r_tstart <= '0;
            r_tline  <= LONE;
            r_esc    <= 1'b0;
            r_halt   <= 1'b0;
        end else if (i_take) begin
            r_mode   <= n_mode;
            r_wlen   <= n_wlen;
            r_pos    <= n_pos;
            r_line   <= n_line;
            r_tstart <= n_tstart;
            r_tline  <= n_tline;
            r_esc    <= n_esc;
            r_halt   <= n_halt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) r_wbuf <= n_wbuf;
    end

endmodule

/* hdl/c_token_lexer.sv */
// Each accepted byte is tokenised in the cycle it is accepted; its results
// enter the result queue and leave it one per cycle while i_stall is low.
// A byte is accepted every cycle while the four-entry result queue has room
// for two results; a byte yields at most two results.
// Reset is synchronous and active low; it empties the queue, returns the
// scanner to idle at offset zero on line one, and clears the halted state.
module c_token_lexer
    import ctl_pkg::*;
#(
    parameter int OFFSET_BITS   = DEF_OFFSET_BITS,
    parameter int LINE_BITS     = DEF_LINE_BITS,
    parameter int KEYWORD_CHARS = DEF_KEYWORD_CHARS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [7:0]             i_text_byte,
    input  logic                   i_end_of_text,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [6:0]             o_token_kind,
    output logic [OFFSET_BITS-1:0] o_start_offset,
    output logic [OFFSET_BITS-1:0] o_end_offset,
    output logic [LINE_BITS-1:0]   o_line_number,
    output logic [2:0]             o_error_code,
    output logic                   o_last_of_run
);

    logic                   take, pop;
    logic [1:0]             s_count;
    t_kind                  s_kind  [2];
    logic [OFFSET_BITS-1:0] s_start [2];
    logic [OFFSET_BITS-1:0] s_end   [2];
    logic [LINE_BITS-1:0]   s_line  [2];
    t_err                   s_err   [2];
    logic                   s_last  [2];

    t_kind                  r_qkind  [4];
    logic [OFFSET_BITS-1:0] r_qstart [4];
    logic [OFFSET_BITS-1:0] r_qend   [4];
    logic [LINE_BITS-1:0]   r_qline  [4];
    t_err                   r_qerr   [4];
    logic                   r_qlast  [4];
    logic [1:0]             r_wp, r_rp;
    logic [2:0]             r_cnt, n_cnt;
    logic [1:0]             push;

    assign o_stall = r_cnt > 3'd2;
    assign take    = i_valid && !o_stall;
    assign o_valid = r_cnt != 3'd0;
    assign pop     = o_valid && !i_stall;
    assign push    = take ? s_count : 2'd0;
    assign n_cnt   = r_cnt + {1'b0, push} - {2'b00, pop};

    ctl_scan #(
        .OFFSET_BITS   (OFFSET_BITS),
        .LINE_BITS     (LINE_BITS),
        .KEYWORD_CHARS (KEYWORD_CHARS)
    ) u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (take),
        .i_text_byte   (i_text_byte),
        .i_end_of_text (i_end_of_text),
        .o_count       (s_count),
        .o_kind        (s_kind),
        .o_start       (s_start),
        .o_end         (s_end),
        .o_line        (s_line),
        .o_err         (s_err),
        .o_last        (s_last)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + push;
            r_rp  <= r_rp + {1'b0, pop};
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 2; j++) begin
            if (2'(j) < push) begin
                r_qkind[r_wp + 2'(j)]  <= s_kind[j];
                r_qstart[r_wp + 2'(j)] <= s_start[j];
                r_qend[r_wp + 2'(j)]   <= s_end[j];
                r_qline[r_wp + 2'(j)]  <= s_line[j];
                r_qerr[r_wp + 2'(j)]   <= s_err[j];
                r_qlast[r_wp + 2'(j)]  <= s_last[j];
            end
        end
    end

    assign o_token_kind   = r_qkind[r_rp];
    assign o_start_offset = r_qstart[r_rp];
    assign o_end_offset   = r_qend[r_rp];
    assign o_line_number  = r_qline[r_rp];
    assign o_error_code   = r_qerr[r_rp];
    assign o_last_of_run  = r_qlast[r_rp];

endmodule
